FILE: rtl/ura_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ura_pkg
// Types and constants shared by the ultrasonic range averager.
// ----------------------------------------------------------------------------
package ura_pkg;

  localparam int unsigned MaxSamplesDef = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSamples = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScale   = 2'd2;

  localparam logic [7:0]  TimeoutRst = 8'd10;
  localparam logic [4:0]  SamplesRst = 5'd4;
  localparam logic [15:0] ScaleRst   = 16'd1114;

  localparam logic [7:0] DistLost = 8'd255;

  localparam logic ActTick    = 1'b0;
  localparam logic ActCapture = 1'b1;

  typedef struct packed {
    logic        action;
    logic        channel;
    logic [15:0] pulse_width;
    logic [1:0]  overflow_mask;
  } in_t;

  typedef struct packed {
    logic [1:0] sensor_done;
    logic [7:0] distance;
    logic       new_reading;
    logic       timed_out;
    logic [1:0] next_trigger;
    logic       last_result;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/ultrasonic_range_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_averager
// Two echo-capture channels, four sensors, averaged and scaled distances.
// ----------------------------------------------------------------------------
// A capture request is taken without giving a result. A tick request
// gives zero, one or two results (channel 0 first) and holds the input until
// it has finished; a completion that publishes a fresh reading also runs
// the bit-serial restoring divider (sum / N) and the bit-serial shift-add
// multiplier (average * scale), one bit a cycle each over SW = 16 +
// clog2(MAX_SAMPLES) bits (20 by default), and then writes the product back
// into the sensor's distance. A full output register stalls the
// block until it is taken. Configuration writes are taken at any time but
// must only be issued while the block is idle.
module ultrasonic_range_averager #(
  parameter int unsigned MAX_SAMPLES = ura_pkg::MaxSamplesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ura_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ura_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire ura_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ura_pkg::out_t                      out_data_o
);
  import ura_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = 16 + $clog2(MAX_SAMPLES);
  localparam int unsigned SCW = $clog2(SW);

  logic [7:0]  timeout_q;
  logic [4:0]  samples_q;
  logic [15:0] scale_q;

  logic [7:0]    wait_q    [2];
  logic [7:0]    wait_d    [2];
  logic [1:0]    pend_q,   pend_d;
  logic [15:0]   width_q   [2];
  logic [15:0]   width_d   [2];
  logic [1:0]    pair_q,   pair_d;
  logic [CW-1:0] cnt_q     [4];
  logic [CW-1:0] cnt_d     [4];
  logic [SW-1:0] sum_q     [4];
  logic [SW-1:0] sum_d     [4];
  logic [7:0]    dist_q    [4];
  logic [7:0]    dist_d    [4];

  state_e        state_q, state_d;
  logic [1:0]    done_q, done_d;
  logic [1:0]    lost_q, lost_d;
  logic          chan_q, chan_d;
  logic          fresh_q, fresh_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [SW-1:0] div_q, div_d;
  logic [15:0]   hi_q, hi_d;
  logic [SCW-1:0] step_q, step_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;
  logic          mul_wb_q;

  logic          in_acc;
  logic          out_free;
  logic [1:0]    sel;
  logic [6:0]    cfg_n;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] cnt_inc;
  logic [SW-1:0] sum_inc;
  logic [CW:0]   trial;
  logic [CW:0]   trial_sub;
  logic          q_bit;
  logic [16:0]   madd;
  logic [SW+15:0] prod;
  logic [7:0]    dist_mul;
  logic [7:0]    wait_inc [2];
  logic [1:0]    lost_now;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sel = {chan_q, pair_q[chan_q]};

  // Clamp N into 1..MAX_SAMPLES.
  always_comb begin
    cfg_n = {2'b00, samples_q};
    if (cfg_n == 7'd0) begin
      n_eff = CW'(1);
    end else if (cfg_n > 7'(MAX_SAMPLES)) begin
      n_eff = CW'(MAX_SAMPLES);
    end else begin
      n_eff = cfg_n[CW-1:0];
    end
  end

  assign cnt_inc = cnt_q[sel] + CW'(1);
  assign sum_inc = sum_q[sel] + SW'(width_q[chan_q]);

  // One restoring division step.
  assign trial     = {rem_q, div_q[SW-1]};
  assign trial_sub = trial - {1'b0, n_eff};
  assign q_bit     = (trial >= {1'b0, n_eff});

  // One shift-add multiplication step.
  assign madd = {1'b0, hi_q} + (div_q[0] ? {1'b0, scale_q} : 17'd0);

  assign prod     = {hi_q, div_q};
  assign dist_mul = (prod[SW+15:24] != '0) ? DistLost : prod[23:16];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      wait_inc[c] = wait_q[c] + 8'd1;
      lost_now[c] = (wait_inc[c] == timeout_q) || in_data_i.overflow_mask[c];
    end
  end

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    lost_d      = lost_q;
    chan_d      = chan_q;
    fresh_d     = fresh_q;
    rem_d       = rem_q;
    div_d       = div_q;
    hi_d        = hi_q;
    step_d      = step_q;
    pend_d      = pend_q;
    pair_d      = pair_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    for (int c = 0; c < 2; c++) begin
      wait_d[c]  = wait_q[c];
      width_d[c] = width_q[c];
    end
    for (int s = 0; s < 4; s++) begin
      cnt_d[s]  = cnt_q[s];
      sum_d[s]  = sum_q[s];
      dist_d[s] = dist_q[s];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == ActCapture) begin
            width_d[in_data_i.channel] = in_data_i.pulse_width;
            pend_d[in_data_i.channel]  = 1'b1;
          end else begin
            for (int c = 0; c < 2; c++) begin
              done_d[c] = lost_now[c] || pend_q[c];
              lost_d[c] = lost_now[c];
              wait_d[c] = (lost_now[c] || pend_q[c]) ? 8'd0 : wait_inc[c];
              if (lost_now[c] || pend_q[c]) begin
                pend_d[c] = 1'b0;
              end
            end
            chan_d  = 1'b0;
            state_d = ST_SEL;
          end
        end
      end
      ST_SEL: begin
        if (!done_q[chan_q]) begin
          chan_d = 1'b1;
          if (chan_q) begin
            state_d = ST_IDLE;
          end
        end else if (lost_q[chan_q]) begin
          dist_d[sel] = DistLost;
          cnt_d[sel]  = '0;
          sum_d[sel]  = '0;
          fresh_d     = 1'b0;
          state_d     = ST_EMIT;
        end else if (cnt_inc >= n_eff) begin
          cnt_d[sel] = '0;
          sum_d[sel] = '0;
          div_d      = sum_inc;
          rem_d      = '0;
          step_d     = SCW'(SW - 1);
          state_d    = ST_DIV;
        end else begin
          cnt_d[sel] = cnt_inc;
          sum_d[sel] = sum_inc;
          fresh_d    = 1'b0;
          state_d    = ST_EMIT;
        end
      end
      ST_DIV: begin
        rem_d  = q_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
        div_d  = {div_q[SW-2:0], q_bit};
        step_d = step_q - SCW'(1);
        if (step_q == '0) begin
          hi_d    = '0;
          step_d  = SCW'(SW - 1);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        hi_d   = madd[16:1];
        div_d  = {madd[0], div_q[SW-1:1]};
        step_d = step_q - SCW'(1);
        if (step_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold while the finished product lands in the distance.
        if (out_free && !mul_wb_q) begin
          out_d.sensor_done  = sel;
          out_d.distance     = dist_q[sel];
          out_d.new_reading  = fresh_q;
          out_d.timed_out    = lost_q[chan_q];
          out_d.next_trigger = {chan_q, ~pair_q[chan_q]};
          out_d.last_result  = chan_q || !done_q[1];
          out_valid_d        = 1'b1;
          pair_d[chan_q]     = ~pair_q[chan_q];
          chan_d             = 1'b1;
          state_d            = chan_q ? ST_IDLE : ST_SEL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Mark the reading fresh as the multiplier ends; the product lands later via mul_wb_q.
    if (state_q == ST_MUL && step_q == '0) begin
      fresh_d = 1'b1;
    end
  end

  // Multiplier output is written in the cycle after the last step, in EMIT.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_wb_q <= 1'b0;
    end else begin
      mul_wb_q <= (state_q == ST_MUL) && (step_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutRst;
      samples_q   <= SamplesRst;
      scale_q     <= ScaleRst;
      state_q     <= ST_IDLE;
      done_q      <= '0;
      lost_q      <= '0;
      chan_q      <= 1'b0;
      fresh_q     <= 1'b0;
      step_q      <= '0;
      pend_q      <= '0;
      pair_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        wait_q[c]  <= '0;
        width_q[c] <= '0;
      end
      for (int s = 0; s < 4; s++) begin
        cnt_q[s]  <= '0;
        sum_q[s]  <= '0;
        dist_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegTimeout: timeout_q <= cfg_data_i[7:0];
          RegSamples: samples_q <= cfg_data_i[4:0];
          RegScale:   scale_q   <= cfg_data_i;
          default:    ;
        endcase
      end
      state_q     <= state_d;
      done_q      <= done_d;
      lost_q      <= lost_d;
      chan_q      <= chan_d;
      fresh_q     <= fresh_d;
      step_q      <= step_d;
      pend_q      <= pend_d;
      pair_q      <= pair_d;
      out_valid_q <= out_valid_d;
      for (int c = 0; c < 2; c++) begin
        wait_q[c]  <= wait_d[c];
        width_q[c] <= width_d[c];
      end
      for (int s = 0; s < 4; s++) begin
        cnt_q[s] <= cnt_d[s];
        sum_q[s] <= sum_d[s];
        if (mul_wb_q && (2'(s) == sel)) begin
          dist_q[s] <= dist_mul;
        end else begin
          dist_q[s] <= dist_d[s];
        end
      end
    end
  end

  // Datapath and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    hi_q  <= hi_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_range_averager testbench
// Drives capture and tick requests through the valid/stall input, predicts
// every published sensor reading in a local model of the four sensors, and
// compares each result taken from the output field by field. Phases cover
// reset settings, extreme settings, the zero timeout wrap, shrinking sample
// counts and a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import ura_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int SettleCycles = 250;
  localparam int LongHold     = 300;
  localparam int StuckLimit   = 3000;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  ultrasonic_range_averager u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the configuration and of the sensor state
  logic [7:0]  cur_timeout = TimeoutRst;
  logic [4:0]  cur_samples = SamplesRst;
  logic [15:0] cur_scale   = ScaleRst;

  logic [7:0]  wait_cnt  [2] = '{default: '0};
  logic        cap_pend  [2] = '{default: '0};
  logic [15:0] cap_width [2] = '{default: '0};
  logic        pair_sel  [2] = '{default: '0};
  logic [4:0]  samp_cnt  [4] = '{default: '0};
  logic [19:0] width_sum [4] = '{default: '0};
  logic [7:0]  sensor_dist [4] = '{default: '0};

  in_t  pending_q [$];
  out_t reading_q [$];

  int mismatches = 0;
  bit idle_on = 1'b1;
  bit no_gaps = 1'b0;
  int long_hold_seq = 0;

  function automatic void predict_readings(input in_t req);
    out_t        res [2];
    int          n_res;
    int          c;
    logic        ch;
    bit          lost;
    bit          fresh;
    logic [1:0]  s;
    logic [4:0]  n_eff;
    logic [19:0] avg;
    logic [35:0] prod;
    n_res = 0;
    if (req.action == ActCapture) begin
      cap_width[req.channel] = req.pulse_width;
      cap_pend[req.channel]  = 1'b1;
      return;
    end
    for (c = 0; c < 2; c++) begin
      ch = c[0];
      lost = 1'b0;
      fresh = 1'b0;
      wait_cnt[c] = wait_cnt[c] + 8'd1;
      if (wait_cnt[c] == cur_timeout || req.overflow_mask[c]) begin
        lost = 1'b1;
        wait_cnt[c] = '0;
      end
      if (!lost && !cap_pend[c]) continue;
      s = {ch, pair_sel[c]};
      if (lost) begin
        // lost echo: publish no-echo distance and drop the running average
        sensor_dist[s] = DistLost;
        width_sum[s] = '0;
        samp_cnt[s] = '0;
      end else begin
        n_eff = (cur_samples == 5'd0) ? 5'd1 :
                (cur_samples > 5'(MaxSamplesDef)) ? 5'(MaxSamplesDef) : cur_samples;
        samp_cnt[s]  = samp_cnt[s] + 5'd1;
        width_sum[s] = width_sum[s] + 20'(cap_width[c]);
        if (samp_cnt[s] >= n_eff) begin
          avg  = width_sum[s] / 20'(n_eff);
          prod = 36'(avg) * 36'(cur_scale);
          sensor_dist[s] = (prod[35:16] > 20'd255) ? DistLost : prod[23:16];
          samp_cnt[s] = '0;
          width_sum[s] = '0;
          fresh = 1'b1;
        end
      end
      pair_sel[c] = ~pair_sel[c];
      cap_pend[c] = 1'b0;
      wait_cnt[c] = '0;
      res[n_res].sensor_done  = s;
      res[n_res].distance     = sensor_dist[s];
      res[n_res].new_reading  = fresh;
      res[n_res].timed_out    = lost;
      res[n_res].next_trigger = {ch, pair_sel[c]};
      res[n_res].last_result  = 1'b0;
      n_res++;
    end
    if (n_res > 0) res[n_res-1].last_result = 1'b1;
    for (c = 0; c < n_res; c++) reading_q.push_back(res[c]);
  endfunction

  function automatic int draw_tx_gap();
    if (no_gaps || !idle_on) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int draw_rx_gap();
    if (!idle_on) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Request driver
  int  tx_wait = 0;
  bit  offer;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_readings(in_data_i);
        offer = 1'b0;
        tx_wait = draw_tx_gap();
      end
      if (!offer) begin
        if (tx_wait > 0) tx_wait--;
        else if (pending_q.size() > 0) begin
          in_data_i <= pending_q.pop_front();
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor
  int   rx_wait = 0;
  int   hold_left = 0;
  int   long_hold_seen = 0;
  out_t want;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reading_q.size() == 0) begin
          $error("unexpected reading for sensor %0d", out_data_o.sensor_done);
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          check_field("sensor_done", want.sensor_done, out_data_o.sensor_done);
          check_field("distance", want.distance, out_data_o.distance);
          check_field("new_reading", want.new_reading, out_data_o.new_reading);
          check_field("timed_out", want.timed_out, out_data_o.timed_out);
          check_field("next_trigger", want.next_trigger, out_data_o.next_trigger);
          check_field("last_result", want.last_result, out_data_o.last_result);
        end
        rx_wait = draw_rx_gap();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (long_hold_seq != long_hold_seen) begin
        long_hold_seen = long_hold_seq;
        hold_left = LongHold;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  // Watchdog: count cycles with work outstanding and no handshake
  int stuck = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (!in_valid_i && pending_q.size() == 0 && reading_q.size() == 0)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= StuckLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      RegTimeout: cur_timeout = data[7:0];
      RegSamples: cur_samples = data[4:0];
      RegScale:   cur_scale   = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_settings(input logic [15:0] tmo, input logic [15:0] n,
                                input logic [15:0] scale);
    write_reg(RegTimeout, tmo);
    write_reg(RegSamples, n);
    write_reg(RegScale, scale);
  endtask

  // Hold until every request is taken and every reading has come, then let
  // a zero-result tick finish inside the block.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || reading_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_width();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic in_t capture_req(input logic ch, input logic [15:0] w);
    in_t r;
    r.action        = ActCapture;
    r.channel       = ch;
    r.pulse_width   = w;
    r.overflow_mask = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic in_t tick_req(input logic [1:0] ovf);
    in_t r;
    r.action        = ActTick;
    r.channel       = 1'($urandom_range(0, 1));
    r.pulse_width   = 16'($urandom());
    r.overflow_mask = ovf;
    return r;
  endfunction

  // Mostly capture-then-tick measurements, plus lone ticks and captures
  task automatic queue_mixed(input int n);
    int         pushed;
    int         kind;
    logic [1:0] cap_mask;
    pushed = 0;
    while (pushed < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        cap_mask = 2'($urandom_range(1, 3));
        if (cap_mask[0]) begin
          pending_q.push_back(capture_req(1'b0, rand_width()));
          pushed++;
        end
        if (cap_mask[1]) begin
          pending_q.push_back(capture_req(1'b1, rand_width()));
          pushed++;
        end
        if ($urandom_range(0, 9) == 0) begin
          pending_q.push_back(capture_req(1'($urandom_range(0, 1)), rand_width()));
          pushed++;
        end
        pending_q.push_back(tick_req(($urandom_range(0, 9) == 0) ?
                                     2'($urandom_range(1, 3)) : 2'b00));
        pushed++;
      end else if (kind < 85) begin
        pending_q.push_back(tick_req(($urandom_range(0, 3) == 0) ?
                                     2'($urandom_range(0, 3)) : 2'b00));
        pushed++;
      end else begin
        pending_q.push_back(capture_req(1'($urandom_range(0, 1)), rand_width()));
        pushed++;
      end
    end
  endtask

  // Keep channel 0 free of captures and overflows so its counter wraps
  task automatic queue_wrap_ticks(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) pending_q.push_back(capture_req(1'b1, rand_width()));
      pending_q.push_back(tick_req({1'($urandom_range(0, 9) == 0), 1'b0}));
    end
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: both lost, overwrite of a pending width, ignored
    // fields, timeout over a pending capture, then a plain timeout
    pending_q.push_back(tick_req(2'b11));
    pending_q.push_back(capture_req(1'b0, 16'hFFFF));
    pending_q.push_back(capture_req(1'b0, 16'h1234));
    pending_q.push_back(capture_req(1'b1, 16'h0000));
    pending_q.push_back(tick_req(2'b00));
    pending_q.push_back(capture_req(1'b0, 16'hABCD));
    pending_q.push_back(capture_req(1'b1, 16'h8000));
    pending_q.push_back(tick_req(2'b01));
    for (i = 0; i < 11; i++) pending_q.push_back(tick_req(2'b00));
    wait_quiet();

    // Single-sample readings at full and zero scale
    write_settings(16'd255, 16'd1, 16'hFFFF);
    pending_q.push_back(capture_req(1'b0, 16'hFFFF));
    pending_q.push_back(capture_req(1'b1, 16'h0000));
    pending_q.push_back(tick_req(2'b00));
    pending_q.push_back(capture_req(1'b0, 16'h0001));
    pending_q.push_back(tick_req(2'b00));
    wait_quiet();
    write_reg(RegScale, 16'h0000);
    pending_q.push_back(capture_req(1'b1, 16'hFFFF));
    pending_q.push_back(tick_req(2'b10));
    pending_q.push_back(tick_req(2'b00));
    wait_quiet();

    // Reset-like settings; upper data bits and an unused index must be dropped
    write_settings(16'hFF0A, 16'hFFE4, 16'd1114);
    write_reg(RegUnused, 16'hFFFF);
    queue_mixed(25);
    wait_quiet();

    write_settings(16'd255, 16'd16, 16'hFFFF);
    queue_mixed(25);
    wait_quiet();

    // Smaller N with partial sums left over; no idling
    idle_on = 1'b0;
    write_settings(16'd3, 16'd2, 16'd0);
    queue_mixed(20);
    wait_quiet();
    idle_on = 1'b1;

    // Zero timeout fires on counter wrap; N above the maximum clamps
    write_settings(16'd0, 16'd31, 16'd40000);
    queue_wrap_ticks(270);
    wait_quiet();

    // Back up the block with a long output hold and a sender that never pauses
    write_settings(16'd20, 16'd1, 16'd30000);
    no_gaps = 1'b1;
    queue_mixed(25);
    long_hold_seq++;
    wait_quiet();
    no_gaps = 1'b0;

    // Every tick times out; N of zero acts as one
    write_settings(16'd1, 16'd0, 16'd12345);
    queue_mixed(10);
    wait_quiet();

    write_settings(16'($urandom_range(4, 40)), 16'($urandom_range(1, 16)),
                   16'($urandom_range(0, 65535)));
    queue_mixed(20);
    wait_quiet();

    if (reading_q.size() != 0) begin
      $error("%0d readings never arrived", reading_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
